@@ rtl/core/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, field widths and codes of the layered path relaxation unit.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // default sizes of the storage
  localparam int unsigned ZONE_SLOTS_DEF = 16;
  localparam int unsigned MAX_DAYS_DEF   = 512;

  // fixed field widths
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned ZONE_W    = 9;
  localparam int unsigned SLOTF_W   = 4;
  localparam int unsigned EDAY_W    = 10;
  localparam int unsigned COST_W    = 16;
  localparam int unsigned EDGE_ID_W = 16;
  localparam int unsigned RDAY_W    = 9;
  localparam int unsigned DAYO_W    = 10;
  localparam int unsigned DIST_W    = 25;
  localparam int unsigned LIM_W     = 17;

  // run tag kept with each restore entry
  localparam int unsigned TAG_W = 4;

  // configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_COST_LIMIT = 2'd0;
  localparam logic [1:0] REG_START_SLOT = 2'd1;
  localparam logic [1:0] REG_START_ZONE = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 3'd0,
    CMD_OPEN  = 3'd1,
    CMD_RELAX = 3'd2,
    CMD_CLOSE = 3'd3,
    CMD_READ  = 3'd4
  } lpr_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } lpr_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
    logic clr_step;
  } lpr_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic start_wrap;
    logic clr_last;
    logic out_free;
  } lpr_sts_t;

endpackage

@@ rtl/core/lpr_ram.sv @@
// ----------------------------------------------------------------------------
// lpr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/lpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: accepts an item, commits it once the result register is free,
// and runs the restore table clearing pass.
// ----------------------------------------------------------------------------
module lpr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpr_pkg::lpr_sts_t sts_i,
  output lpr_pkg::lpr_ctl_t ctl_o
);
  import lpr_pkg::*;

  lpr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    ctl_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = sts_i.start_wrap ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/lpr_datapath.sv @@
// ----------------------------------------------------------------------------
// lpr_datapath
// Distance rows, reach marks, restore table, run state and result register.
// ----------------------------------------------------------------------------
module lpr_datapath #(
  parameter int unsigned ZONE_SLOTS = lpr_pkg::ZONE_SLOTS_DEF,
  parameter int unsigned MAX_DAYS   = lpr_pkg::MAX_DAYS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lpr_pkg::lpr_ctl_t                  ctl_i,
  output lpr_pkg::lpr_sts_t                  sts_o,
  input  logic        [lpr_pkg::CMD_W-1:0]     command_i,
  input  logic        [lpr_pkg::ZONE_W-1:0]    from_zone_i,
  input  logic        [lpr_pkg::SLOTF_W-1:0]   from_slot_i,
  input  logic        [lpr_pkg::ZONE_W-1:0]    to_zone_i,
  input  logic        [lpr_pkg::SLOTF_W-1:0]   to_slot_i,
  input  logic signed [lpr_pkg::EDAY_W-1:0]    edge_day_i,
  input  logic        [lpr_pkg::COST_W-1:0]    edge_cost_i,
  input  logic        [lpr_pkg::EDGE_ID_W-1:0] edge_id_i,
  input  logic        [lpr_pkg::RDAY_W-1:0]    read_day_i,
  input  logic signed [lpr_pkg::LIM_W-1:0]     cost_limit_i,
  input  logic        [lpr_pkg::SLOTF_W-1:0]   start_slot_i,
  input  logic        [lpr_pkg::ZONE_W-1:0]    start_zone_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               relaxed_o,
  output logic                               layer_progress_o,
  output logic        [lpr_pkg::DAYO_W-1:0]    layer_day_o,
  output logic                               dist_valid_o,
  output logic        [lpr_pkg::DIST_W-1:0]    distance_o,
  output logic                               restore_valid_o,
  output logic        [lpr_pkg::EDGE_ID_W-1:0] restore_edge_o,
  output logic        [lpr_pkg::SLOTF_W-1:0]   restore_from_slot_o
);
  import lpr_pkg::*;

  localparam int unsigned SLOT_W = $clog2(ZONE_SLOTS);
  localparam int unsigned DAY_W  = $clog2(MAX_DAYS);
  localparam int unsigned CNT_W  = $clog2(MAX_DAYS + 1);
  localparam int unsigned RA_W   = DAY_W + SLOT_W;
  localparam int unsigned RDEPTH = 1 << RA_W;
  localparam int unsigned RST_W  = TAG_W + EDGE_ID_W + SLOTF_W;

  // item register
  logic [CMD_W-1:0]        cmd_q;
  logic [ZONE_W-1:0]       fz_q, tz_q;
  logic [SLOTF_W-1:0]      fs_q, ts_q;
  logic signed [EDAY_W-1:0] eday_q;
  logic [COST_W-1:0]       cost_q;
  logic [EDGE_ID_W-1:0]    eid_q;
  logic [RDAY_W-1:0]       rday_q;

  // run state
  logic [ZONE_SLOTS-1:0]   mark_q [2];
  logic [ZONE_SLOTS-1:0]   mark_d [2];
  logic                    row_q, row_d;
  logic [CNT_W-1:0]        day_q, day_d;
  logic [ZONE_W-1:0]       src_zone_q, src_zone_d;
  logic [ZONE_W-1:0]       tgt_zone_q, tgt_zone_d;
  logic                    prog_q, prog_d;
  logic [TAG_W-1:0]        epoch_q, epoch_d;
  logic [RA_W-1:0]         clr_cnt_q;

  // result register
  logic                    out_valid_q;
  logic                    res_relaxed_q, res_relaxed_d;
  logic                    res_prog_q, res_prog_d;
  logic [DAYO_W-1:0]       res_day_q;
  logic                    res_dv_q, res_dv_d;
  logic [DIST_W-1:0]       res_dist_q, res_dist_d;
  logic                    res_rv_q, res_rv_d;
  logic [EDGE_ID_W-1:0]    res_re_q, res_re_d;
  logic [SLOTF_W-1:0]      res_rf_q, res_rf_d;

  // memories
  logic [SLOT_W-1:0]       dram_raddr [2];
  logic [SLOT_W-1:0]       dram_waddr [2];
  logic [DIST_W-1:0]       dram_wdata [2];
  logic [DIST_W-1:0]       dram_rdata [2];
  logic                    dram_we    [2];
  logic                    rram_we;
  logic [RA_W-1:0]         rram_waddr, rram_raddr;
  logic [RST_W-1:0]        rram_wdata, rram_rdata;

  // decoded item
  logic                    is_start, is_open, is_relax, is_close, is_read;
  logic [SLOT_W-1:0]       fs_idx, ts_idx, start_idx, cur_addr_in, ts_idx_in;
  logic                    fs_in, ts_in, start_in, rday_in;
  logic                    day_ok, zone_ok, eday_ok, cost_ok, hit;
  logic [DIST_W-1:0]       d_cur, d_nxt, sat_sum;
  logic [DIST_W:0]         sum;
  logic                    nxt_row;

  assign is_start = (cmd_q == CMD_START);
  assign is_open  = (cmd_q == CMD_OPEN);
  assign is_relax = (cmd_q == CMD_RELAX);
  assign is_close = (cmd_q == CMD_CLOSE);
  assign is_read  = (cmd_q == CMD_READ);
  assign nxt_row  = ~row_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= command_i;
      fz_q   <= from_zone_i;
      fs_q   <= from_slot_i;
      tz_q   <= to_zone_i;
      ts_q   <= to_slot_i;
      eday_q <= edge_day_i;
      cost_q <= edge_cost_i;
      eid_q  <= edge_id_i;
      rday_q <= read_day_i;
    end
  end

  // ram read addresses come straight from the ports at the accept edge
  assign ts_idx_in   = SLOT_W'(to_slot_i);
  assign cur_addr_in = (command_i == CMD_READ) ? ts_idx_in : SLOT_W'(from_slot_i);

  assign fs_idx    = SLOT_W'(fs_q);
  assign ts_idx    = SLOT_W'(ts_q);
  assign start_idx = SLOT_W'(start_slot_i);
  assign fs_in     = (9'(fs_q) < 9'(ZONE_SLOTS));
  assign ts_in     = (9'(ts_q) < 9'(ZONE_SLOTS));
  assign start_in  = (9'(start_slot_i) < 9'(ZONE_SLOTS));
  assign rday_in   = (13'(rday_q) < 13'(MAX_DAYS));

  assign d_cur = dram_rdata[row_q];
  assign d_nxt = dram_rdata[nxt_row];

  // relax qualification
  assign day_ok  = (day_q < CNT_W'(MAX_DAYS));
  assign zone_ok = (fz_q == src_zone_q) && (tz_q == tgt_zone_q);
  assign eday_ok = (&eday_q) ||
                   (!eday_q[EDAY_W-1] && (16'(eday_q[EDAY_W-2:0]) == 16'(day_q)));
  assign cost_ok = (&cost_limit_i) ||
                   (!cost_limit_i[LIM_W-1] && (LIM_W'(cost_q) <= cost_limit_i[LIM_W-1:0]));

  assign sum     = (DIST_W+1)'(d_cur) + (DIST_W+1)'(cost_q);
  assign sat_sum = sum[DIST_W] ? '1 : sum[DIST_W-1:0];

  always_comb begin
    hit = 1'b0;
    if (is_relax && fs_in && ts_in && day_ok && zone_ok && eday_ok && cost_ok) begin
      if (mark_q[row_q][fs_idx]) begin
        hit = !mark_q[nxt_row][ts_idx] || (d_nxt > sat_sum);
      end
    end
  end

  // distance rows, one ram per row
  for (genvar k = 0; k < 2; k++) begin : g_row
    assign dram_raddr[k] = (1'(k) == row_q) ? cur_addr_in : ts_idx_in;
    assign dram_we[k]    = ctl_i.commit &&
                           ((is_start && start_in && (1'(k) == row_q)) ||
                            (hit && (1'(k) == nxt_row)));
    assign dram_waddr[k] = is_start ? start_idx : ts_idx;
    assign dram_wdata[k] = is_start ? '0 : sat_sum;

    lpr_ram #(
      .WIDTH (DIST_W),
      .DEPTH (ZONE_SLOTS)
    ) u_row_ram (
      .clk_i   (clk_i),
      .we_i    (dram_we[k]),
      .waddr_i (dram_waddr[k]),
      .wdata_i (dram_wdata[k]),
      .re_i    (ctl_i.load),
      .raddr_i (dram_raddr[k]),
      .rdata_o (dram_rdata[k])
    );
  end

  // restore table: an entry is valid when its tag equals the run tag
  assign rram_we    = ctl_i.clr_step || (ctl_i.commit && hit);
  assign rram_waddr = ctl_i.clr_step ? clr_cnt_q : {DAY_W'(day_q), ts_idx};
  assign rram_wdata = ctl_i.clr_step ? '0 : {epoch_q, eid_q, fs_q};
  assign rram_raddr = {DAY_W'(read_day_i), ts_idx_in};

  lpr_ram #(
    .WIDTH (RST_W),
    .DEPTH (RDEPTH)
  ) u_restore_ram (
    .clk_i   (clk_i),
    .we_i    (rram_we),
    .waddr_i (rram_waddr),
    .wdata_i (rram_wdata),
    .re_i    (ctl_i.load),
    .raddr_i (rram_raddr),
    .rdata_o (rram_rdata)
  );

  // state update and result
  always_comb begin
    mark_d        = mark_q;
    row_d         = row_q;
    day_d         = day_q;
    src_zone_d    = src_zone_q;
    tgt_zone_d    = tgt_zone_q;
    prog_d        = prog_q;
    epoch_d       = epoch_q;
    res_relaxed_d = 1'b0;
    res_prog_d    = prog_q;
    res_dv_d      = 1'b0;
    res_dist_d    = '0;
    res_rv_d      = 1'b0;
    res_re_d      = '0;
    res_rf_d      = '0;
    case (cmd_q)
      CMD_START: begin
        mark_d[0] = '0;
        mark_d[1] = '0;
        if (start_in) begin
          mark_d[row_q][start_idx] = 1'b1;
        end
        day_d      = '0;
        src_zone_d = start_zone_i;
        prog_d     = 1'b0;
        res_prog_d = 1'b0;
        epoch_d    = (&epoch_q) ? TAG_W'(1) : epoch_q + TAG_W'(1);
      end
      CMD_OPEN: begin
        tgt_zone_d      = tz_q;
        mark_d[nxt_row] = '0;
        prog_d          = 1'b0;
        res_prog_d      = 1'b0;
      end
      CMD_RELAX: begin
        if (hit) begin
          mark_d[nxt_row][ts_idx] = 1'b1;
          prog_d                  = 1'b1;
          res_relaxed_d           = 1'b1;
          res_prog_d              = 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (prog_q) begin
          row_d      = nxt_row;
          src_zone_d = tgt_zone_q;
          if (day_ok) begin
            day_d = day_q + CNT_W'(1);
          end
        end
        prog_d = 1'b0;
      end
      CMD_READ: begin
        if (ts_in) begin
          if (mark_q[row_q][ts_idx]) begin
            res_dv_d   = 1'b1;
            res_dist_d = d_cur;
          end
          if (rday_in && (rram_rdata[RST_W-1 -: TAG_W] == epoch_q)) begin
            res_rv_d = 1'b1;
            res_re_d = rram_rdata[SLOTF_W +: EDGE_ID_W];
            res_rf_d = rram_rdata[SLOTF_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q[0]   <= '0;
      mark_q[1]   <= '0;
      row_q       <= 1'b0;
      day_q       <= '0;
      src_zone_q  <= '0;
      tgt_zone_q  <= '0;
      prog_q      <= 1'b0;
      epoch_q     <= TAG_W'(1);
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.commit) begin
        mark_q     <= mark_d;
        row_q      <= row_d;
        day_q      <= day_d;
        src_zone_q <= src_zone_d;
        tgt_zone_q <= tgt_zone_d;
        prog_q     <= prog_d;
        epoch_q    <= epoch_d;
      end
      if (ctl_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + RA_W'(1);
      end
      if (ctl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      res_relaxed_q <= res_relaxed_d;
      res_prog_q    <= res_prog_d;
      res_day_q     <= DAYO_W'(day_d);
      res_dv_q      <= res_dv_d;
      res_dist_q    <= res_dist_d;
      res_rv_q      <= res_rv_d;
      res_re_q      <= res_re_d;
      res_rf_q      <= res_rf_d;
    end
  end

  assign sts_o.start_wrap = is_start && (&epoch_q);
  assign sts_o.clr_last   = &clr_cnt_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign relaxed_o           = res_relaxed_q;
  assign layer_progress_o    = res_prog_q;
  assign layer_day_o         = res_day_q;
  assign dist_valid_o        = res_dv_q;
  assign distance_o          = res_dist_q;
  assign restore_valid_o     = res_rv_q;
  assign restore_edge_o      = res_re_q;
  assign restore_from_slot_o = res_rf_q;

endmodule

@@ rtl/core/layered_path_relaxation_unit.sv @@
// ----------------------------------------------------------------------------
// layered_path_relaxation_unit
// Min-plus relaxation engine over day layers with a restore table for
// software traceback.
// ----------------------------------------------------------------------------
//  channel   handshake                  moves
//  input     in_valid_i / in_ready_o    one command item
//  output    out_valid_o / out_ready_i  one result item per command
//  config    psel/penable/pwrite        register write, pready always high
//
//  Every item is accepted, then in the execute state the registered read of the
//  distance row rams and the restore table ram lands and the item commits.
//  A commit waits while the output register holds a result nobody took;
//  the next item is accepted while a finished result still waits.
//  After reset, and on every fifteenth start run when the run tag wraps,
//  all MAX_DAYS * ZONE_SLOTS restore table entries are swept clean
//  (both rounded up to powers of two, 8192 by default); no item is taken then.
// ----------------------------------------------------------------------------
module layered_path_relaxation_unit #(
  parameter int unsigned ZONE_SLOTS = lpr_pkg::ZONE_SLOTS_DEF,
  parameter int unsigned MAX_DAYS   = lpr_pkg::MAX_DAYS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [lpr_pkg::CMD_W-1:0]     command_i,
  input  logic        [lpr_pkg::ZONE_W-1:0]    from_zone_i,
  input  logic        [lpr_pkg::SLOTF_W-1:0]   from_slot_i,
  input  logic        [lpr_pkg::ZONE_W-1:0]    to_zone_i,
  input  logic        [lpr_pkg::SLOTF_W-1:0]   to_slot_i,
  input  logic signed [lpr_pkg::EDAY_W-1:0]    edge_day_i,
  input  logic        [lpr_pkg::COST_W-1:0]    edge_cost_i,
  input  logic        [lpr_pkg::EDGE_ID_W-1:0] edge_id_i,
  input  logic        [lpr_pkg::RDAY_W-1:0]    read_day_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 relaxed_o,
  output logic                                 layer_progress_o,
  output logic        [lpr_pkg::DAYO_W-1:0]    layer_day_o,
  output logic                                 dist_valid_o,
  output logic        [lpr_pkg::DIST_W-1:0]    distance_o,
  output logic                                 restore_valid_o,
  output logic        [lpr_pkg::EDGE_ID_W-1:0] restore_edge_o,
  output logic        [lpr_pkg::SLOTF_W-1:0]   restore_from_slot_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [lpr_pkg::PADDR_W-1:0]   paddr,
  input  logic        [lpr_pkg::PDATA_W-1:0]   pwdata,
  output logic        [lpr_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready
);
  import lpr_pkg::*;

  logic signed [LIM_W-1:0]   cost_limit_q;
  logic [SLOTF_W-1:0]        start_slot_q;
  logic [ZONE_W-1:0]         start_zone_q;
  logic                      cfg_we;
  logic [1:0]                reg_idx;
  lpr_ctl_t                  ctl;
  lpr_sts_t                  sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_limit_q <= '1;
      start_slot_q <= '0;
      start_zone_q <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_COST_LIMIT: cost_limit_q <= pwdata[LIM_W-1:0];
        REG_START_SLOT: start_slot_q <= pwdata[SLOTF_W-1:0];
        REG_START_ZONE: start_zone_q <= pwdata[ZONE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COST_LIMIT: prdata = PDATA_W'(cost_limit_q);
      REG_START_SLOT: prdata = PDATA_W'(start_slot_q);
      REG_START_ZONE: prdata = PDATA_W'(start_zone_q);
      default:        prdata = '0;
    endcase
  end

  lpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  lpr_datapath #(
    .ZONE_SLOTS (ZONE_SLOTS),
    .MAX_DAYS   (MAX_DAYS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .sts_o               (sts),
    .command_i           (command_i),
    .from_zone_i         (from_zone_i),
    .from_slot_i         (from_slot_i),
    .to_zone_i           (to_zone_i),
    .to_slot_i           (to_slot_i),
    .edge_day_i          (edge_day_i),
    .edge_cost_i         (edge_cost_i),
    .edge_id_i           (edge_id_i),
    .read_day_i          (read_day_i),
    .cost_limit_i        (cost_limit_q),
    .start_slot_i        (start_slot_q),
    .start_zone_i        (start_zone_q),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .relaxed_o           (relaxed_o),
    .layer_progress_o    (layer_progress_o),
    .layer_day_o         (layer_day_o),
    .dist_valid_o        (dist_valid_o),
    .distance_o          (distance_o),
    .restore_valid_o     (restore_valid_o),
    .restore_edge_o      (restore_edge_o),
    .restore_from_slot_o (restore_from_slot_o)
  );

endmodule

@@ rtl/core/lpr_checker.sv @@
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks of the layered path relaxation unit, bound to the top.
// ----------------------------------------------------------------------------
module lpr_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 relaxed_o,
  input logic                                 layer_progress_o,
  input logic        [lpr_pkg::DIST_W-1:0]    distance_o,
  input logic                                 dist_valid_o,
  input logic                                 restore_valid_o,
  input logic        [lpr_pkg::EDGE_ID_W-1:0] restore_edge_o,
  input logic        [lpr_pkg::SLOTF_W-1:0]   restore_from_slot_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) &&
      $stable(restore_edge_o) && $stable(relaxed_o))
    else $error("result changed while stalled");

  // a successful relax always leaves the layer with progress
  a_relax_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relaxed_o |-> layer_progress_o)
    else $error("relax without layer progress");

  // relax results and read results never mix
  a_relax_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relaxed_o |-> !dist_valid_o && !restore_valid_o)
    else $error("relax result carries read fields");

  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dist_valid_o |-> distance_o == '0)
    else $error("distance set without valid");

  a_restore_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !restore_valid_o |-> restore_edge_o == '0 && restore_from_slot_o == '0)
    else $error("restore fields set without valid");

endmodule

bind layered_path_relaxation_unit lpr_checker u_lpr_checker (.*);
